// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

	// Order registers hold 0 to ORDER_COUNT, up to 16.
	localparam int OW = 5;
	// Wide enough for any frame index, any frame count and any buddy address.
	localparam int EW = 18;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] RS_OK    = 2'd0;
	localparam logic [1:0] RS_OOM   = 2'd1;
	localparam logic [1:0] RS_DFREE = 2'd2;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_SCAN,
		S_A_TAKE,
		S_A_FIXN,
		S_A_SPLIT,
		S_A_PUSH,
		S_A_LINK,
		S_F_RD,
		S_F_CHK,
		S_F_BUD,
		S_F_BCHK,
		S_F_UNP,
		S_F_UNN,
		S_F_LINK,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_SCAN,
		OP_POP_RD,
		OP_POP_TAKE,
		OP_POP_FIX,
		OP_DEC,
		OP_SPLIT_PUSH,
		OP_LINK_FIX,
		OP_ALLOC_FIN,
		OP_OOM,
		OP_DFREE,
		OP_FREE_RD,
		OP_FREE_MARK,
		OP_BUD_RD,
		OP_BUD_TAKE,
		OP_UNLINK_P,
		OP_UNLINK_N,
		OP_PUSH
	} dp_op_t;

	typedef struct packed {
		logic clear_last;
		logic ord_ge_count;
		logic head_empty;
		logic split_more;
		logic idx_bad;
		logic rd_in_use;
		logic merge_go;
		logic buddy_ok;
	} dp_stat_t;

	// Smallest k with 2**k >= cnt; a count of zero or one gives order 0.
	function automatic logic [OW-1:0] count_order(input logic [11:0] cnt);
		logic [11:0] c1;
		logic [OW-1:0] k;
		c1 = (cnt == 12'd0) ? 12'd0 : cnt - 12'd1;
		k = '0;
		for (int i = 0; i < 12; i++) begin
			if (c1[i]) begin
				k = OW'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

// ===== hdl/bpa_datapath.sv =====
module bpa_datapath import bpa_pkg::*; #(
	parameter int FRAME_TOTAL = 4096,
	parameter int ORDER_COUNT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_t      op,
	input  logic [11:0] page_count,
	input  logic [11:0] block_index,
	output dp_stat_t    stat,
	output logic [1:0]  status,
	output logic [11:0] result_index,
	output logic [3:0]  result_order
);

	localparam int AW = $clog2(FRAME_TOTAL);
	localparam int LW = AW + 1;
	localparam int HW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
	localparam int TOP = ORDER_COUNT - 1;
	localparam int Size = 1 << TOP;
	localparam int NBLK = FRAME_TOTAL / Size;
	localparam logic [LW-1:0] LINK_NONE = LW'(FRAME_TOTAL);

	logic [3:0]    ord_mem  [FRAME_TOTAL];
	logic          use_mem  [FRAME_TOTAL];
	logic [LW-1:0] next_mem [FRAME_TOTAL];
	logic [LW-1:0] prev_mem [FRAME_TOTAL];

	logic [LW-1:0] head_q [ORDER_COUNT];
	logic [AW-1:0] clr_q;

	logic [AW-1:0] idx_q, blk_q;
	logic [OW-1:0] ord_q, k_q;
	logic [LW-1:0] nbr_q, prv_q;
	logic          bad_q;
	logic [3:0]    rd_ord_q;
	logic          rd_use_q;
	logic [LW-1:0] rd_next_q, rd_prev_q;
	logic [1:0]    res_status_q;
	logic [11:0]   res_index_q;
	logic [3:0]    res_order_q;

	logic [LW-1:0] head_sel;
	logic [EW-1:0] bud_ext, split_ext, bi_ext, idx_ext;
	logic [OW-1:0] k_load, ord_clip;

	logic          re;
	logic [AW-1:0] ra, wa;
	logic          we_ord, we_use, we_next, we_prev;
	logic [3:0]    w_ord;
	logic          w_use;
	logic [LW-1:0] w_next, w_prev;

	logic [3:0]    init_ord;
	logic [LW-1:0] init_next, init_prev;

	assign head_sel  = (ord_q < OW'(ORDER_COUNT)) ? head_q[ord_q[HW-1:0]] : LINK_NONE;
	assign idx_ext   = EW'(idx_q);
	assign bud_ext   = idx_ext ^ (EW'(1) << ord_q);
	assign split_ext = idx_ext + (EW'(1) << ord_q);
	assign bi_ext    = EW'(block_index);
	assign k_load    = count_order(page_count);
	assign ord_clip  = (rd_ord_q > 4'(TOP)) ? OW'(TOP) : OW'(rd_ord_q);

	// Reset image of one frame: top-order heads chained in ascending order.
	always_comb begin
		int fi, bno;
		fi = int'(clr_q);
		bno = fi / Size;
		init_ord = 4'd0;
		init_next = LINK_NONE;
		init_prev = LINK_NONE;
		if ((fi % Size == 0) && (bno < NBLK)) begin
			init_ord = 4'(TOP);
			if (bno + 1 < NBLK) begin
				init_next = LW'(fi + Size);
			end
			if (bno > 0) begin
				init_prev = LW'(fi - Size);
			end
		end
	end

	always_comb begin
		re = 1'b0;
		ra = idx_q;
		wa = idx_q;
		we_ord = 1'b0;
		we_use = 1'b0;
		we_next = 1'b0;
		we_prev = 1'b0;
		w_ord = ord_q[3:0];
		w_use = 1'b0;
		w_next = head_sel;
		w_prev = LINK_NONE;
		unique case (op)
			OP_CLEAR: begin
				wa = clr_q;
				we_ord = 1'b1;
				we_use = 1'b1;
				we_next = 1'b1;
				we_prev = 1'b1;
				w_ord = init_ord;
				w_next = init_next;
				w_prev = init_prev;
			end
			OP_POP_RD: begin
				re = 1'b1;
				ra = head_sel[AW-1:0];
			end
			OP_POP_FIX: begin
				wa = nbr_q[AW-1:0];
				we_prev = (nbr_q != LINK_NONE);
			end
			OP_SPLIT_PUSH: begin
				wa = split_ext[AW-1:0];
				we_ord = 1'b1;
				we_use = 1'b1;
				we_next = 1'b1;
				we_prev = 1'b1;
			end
			OP_LINK_FIX: begin
				wa = nbr_q[AW-1:0];
				we_prev = (nbr_q != LINK_NONE);
				w_prev = LW'(blk_q);
			end
			OP_ALLOC_FIN: begin
				we_ord = 1'b1;
				we_use = 1'b1;
				w_ord = k_q[3:0];
				w_use = 1'b1;
			end
			OP_FREE_RD: begin
				re = 1'b1;
			end
			OP_FREE_MARK: begin
				we_use = 1'b1;
			end
			OP_BUD_RD: begin
				re = 1'b1;
				ra = bud_ext[AW-1:0];
			end
			OP_UNLINK_P: begin
				wa = prv_q[AW-1:0];
				we_next = (prv_q != LINK_NONE);
				w_next = nbr_q;
			end
			OP_UNLINK_N: begin
				wa = nbr_q[AW-1:0];
				we_prev = (nbr_q != LINK_NONE);
				w_prev = prv_q;
			end
			OP_PUSH: begin
				we_ord = 1'b1;
				we_use = 1'b1;
				we_next = 1'b1;
				we_prev = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_ord) begin
			ord_mem[wa] <= w_ord;
		end
		if (we_use) begin
			use_mem[wa] <= w_use;
		end
		if (we_next) begin
			next_mem[wa] <= w_next;
		end
		if (we_prev) begin
			prev_mem[wa] <= w_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_ord_q <= ord_mem[ra];
			rd_use_q <= use_mem[ra];
			rd_next_q <= next_mem[ra];
			rd_prev_q <= prev_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_q[i] <= LINK_NONE;
			end
			if (NBLK > 0) begin
				head_q[TOP] <= '0;
			end
		end else begin
			if (op == OP_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			unique case (op)
				OP_POP_TAKE: head_q[ord_q[HW-1:0]] <= rd_next_q;
				OP_SPLIT_PUSH: head_q[ord_q[HW-1:0]] <= LW'(split_ext[AW-1:0]);
				OP_UNLINK_P: begin
					if (prv_q == LINK_NONE) begin
						head_q[ord_q[HW-1:0]] <= nbr_q;
					end
				end
				OP_PUSH: head_q[ord_q[HW-1:0]] <= LW'(idx_q);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				k_q <= k_load;
				ord_q <= k_load;
				idx_q <= bi_ext[AW-1:0];
				bad_q <= (bi_ext >= EW'(FRAME_TOTAL));
			end
			OP_SCAN: ord_q <= ord_q + OW'(1);
			OP_POP_RD: idx_q <= head_sel[AW-1:0];
			OP_POP_TAKE: nbr_q <= rd_next_q;
			OP_DEC: ord_q <= ord_q - OW'(1);
			OP_SPLIT_PUSH: begin
				nbr_q <= head_sel;
				blk_q <= split_ext[AW-1:0];
			end
			OP_ALLOC_FIN: begin
				res_status_q <= RS_OK;
				res_index_q <= idx_ext[11:0];
				res_order_q <= k_q[3:0];
			end
			OP_OOM: begin
				res_status_q <= RS_OOM;
				res_index_q <= '0;
				res_order_q <= '0;
			end
			OP_DFREE: begin
				res_status_q <= RS_DFREE;
				res_index_q <= '0;
				res_order_q <= '0;
			end
			OP_FREE_MARK: ord_q <= ord_clip;
			OP_BUD_RD: blk_q <= bud_ext[AW-1:0];
			OP_BUD_TAKE: begin
				nbr_q <= rd_next_q;
				prv_q <= rd_prev_q;
			end
			OP_UNLINK_N: begin
				ord_q <= ord_q + OW'(1);
				if (blk_q < idx_q) begin
					idx_q <= blk_q;
				end
			end
			OP_PUSH: begin
				nbr_q <= head_sel;
				blk_q <= idx_q;
				res_status_q <= RS_OK;
				res_index_q <= idx_ext[11:0];
				res_order_q <= ord_q[3:0];
			end
			default: begin
			end
		endcase
	end

	assign stat.clear_last   = (clr_q == AW'(FRAME_TOTAL - 1));
	assign stat.ord_ge_count = (ord_q >= OW'(ORDER_COUNT));
	assign stat.head_empty   = (head_sel == LINK_NONE);
	assign stat.split_more   = (ord_q > k_q);
	assign stat.idx_bad      = bad_q;
	assign stat.rd_in_use    = rd_use_q;
	assign stat.merge_go     = (ord_q < OW'(TOP)) && (bud_ext < EW'(FRAME_TOTAL));
	assign stat.buddy_ok     = !rd_use_q && (OW'(rd_ord_q) == ord_q);

	assign status       = res_status_q;
	assign result_index = res_index_q;
	assign result_order = res_order_q;

endmodule

// ===== hdl/bpa_control.sv =====
module bpa_control import bpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     command,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output dp_op_t   op,
	output logic     req_stall,
	output logic     rsp_valid
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					op = OP_LOAD;
					state_d = (command == CMD_FREE) ? S_F_RD : S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				priority if (stat.ord_ge_count) begin
					op = OP_OOM;
					state_d = S_OUT;
				end else if (stat.head_empty) begin
					op = OP_SCAN;
				end else begin
					op = OP_POP_RD;
					state_d = S_A_TAKE;
				end
			end
			S_A_TAKE: begin
				op = OP_POP_TAKE;
				state_d = S_A_FIXN;
			end
			S_A_FIXN: begin
				op = OP_POP_FIX;
				state_d = S_A_SPLIT;
			end
			S_A_SPLIT: begin
				if (stat.split_more) begin
					op = OP_DEC;
					state_d = S_A_PUSH;
				end else begin
					op = OP_ALLOC_FIN;
					state_d = S_OUT;
				end
			end
			S_A_PUSH: begin
				op = OP_SPLIT_PUSH;
				state_d = S_A_LINK;
			end
			S_A_LINK: begin
				op = OP_LINK_FIX;
				state_d = S_A_SPLIT;
			end
			S_F_RD: begin
				if (stat.idx_bad) begin
					op = OP_DFREE;
					state_d = S_OUT;
				end else begin
					op = OP_FREE_RD;
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (!stat.rd_in_use) begin
					op = OP_DFREE;
					state_d = S_OUT;
				end else begin
					op = OP_FREE_MARK;
					state_d = S_F_BUD;
				end
			end
			S_F_BUD: begin
				if (stat.merge_go) begin
					op = OP_BUD_RD;
					state_d = S_F_BCHK;
				end else begin
					op = OP_PUSH;
					state_d = S_F_LINK;
				end
			end
			S_F_BCHK: begin
				if (stat.buddy_ok) begin
					op = OP_BUD_TAKE;
					state_d = S_F_UNP;
				end else begin
					op = OP_PUSH;
					state_d = S_F_LINK;
				end
			end
			S_F_UNP: begin
				op = OP_UNLINK_P;
				state_d = S_F_UNN;
			end
			S_F_UNN: begin
				op = OP_UNLINK_N;
				state_d = S_F_BUD;
			end
			S_F_LINK: begin
				op = OP_LINK_FIX;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// Buddy page allocator. After reset the block sweeps its frame tables once, one frame a
// cycle, and holds req_stall high meanwhile. Requests are then served one at a time
// through a single frame-table port. After the request beat is taken, an allocate scans
// past each empty order, pops a block and splits it down to the order asked for, or
// reports out of memory; a free rejects a bad or unallocated frame, else merges it with
// its buddy while the buddy is free and of the same order, then pushes the block. The
// result is then shown until rsp_stall is low.
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int FRAME_TOTAL = 4096,
	parameter int ORDER_COUNT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        command,
	input  logic [11:0] page_count,
	input  logic [11:0] block_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [11:0] result_index,
	output logic [3:0]  result_order
);

	dp_op_t   op;
	dp_stat_t stat;

	bpa_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (command),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.op        (op),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid)
	);

	bpa_datapath #(
		.FRAME_TOTAL (FRAME_TOTAL),
		.ORDER_COUNT (ORDER_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.page_count   (page_count),
		.block_index  (block_index),
		.stat         (stat),
		.status       (status),
		.result_index (result_index),
		.result_order (result_order)
	);

endmodule
